[rtl/gitp_pkg.sv]
// Shared types and constants for the grid itinerary text parser.
// Used by gitp_core, gitp_rbuf and grid_itinerary_text_parser_unit; no dependencies.
package gitp_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_LEAD,
        PH_ROW_WS,
        PH_ROW_LAST,
        PH_ROW_FIRST,
        PH_COL_WS,
        PH_POST,
        PH_SEP,
        PH_T_WS,
        PH_TIME,
        PH_DISCARD
    } phase_t;

    // Record kinds
    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_WAYPOINT = 2'd1;
    localparam logic [1:0] KIND_DONE     = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_UNEXP_END = 3'd0;
    localparam logic [2:0] ERR_EXP_NUM   = 3'd1;
    localparam logic [2:0] ERR_HEADING   = 3'd2;
    localparam logic [2:0] ERR_LETTER    = 3'd3;
    localparam logic [2:0] ERR_COL_RANGE = 3'd4;
    localparam logic [2:0] ERR_ROW_RANGE = 3'd5;
    localparam logic [2:0] ERR_EXP_T     = 3'd6;
    localparam logic [2:0] ERR_EXP_WS    = 3'd7;

    // Headings
    localparam logic [1:0] HEAD_N = 2'd0;
    localparam logic [1:0] HEAD_E = 2'd1;
    localparam logic [1:0] HEAD_S = 2'd2;
    localparam logic [1:0] HEAD_W = 2'd3;

    // Characters (lower case; upper case folds by setting bit 5)
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_W     = 8'h77;

    // Result buffer depth
    localparam int RB_DEPTH = 4;

    // One result record
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  col;
        logic [3:0]  row;
        logic        col_lead;
        logic [1:0]  heading;
        logic [15:0] time_res;
        logic [2:0]  error_code;
        logic        last;
    } res_t;

    // Records produced by one character: count and up to two records
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage

[rtl/gitp_core.sv]
// Parse state and per-character step of the itinerary parser, in up to two passes.
// Depends on gitp_pkg for phases, codes and record types.
module gitp_core
    import gitp_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int GRID_SIZE = 9
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] ch,
    output push_t      push
);

    localparam int TB = TIME_BITS;
    localparam int CW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

    typedef struct packed {
        phase_t        phase;
        logic [TB-1:0] acc;
        logic [CW-1:0] col;
        logic [CW-1:0] row;
        logic          cf;
        logic          in_start;
    } st_t;

    st_t state_reg, state_next;

    // One pass of the grammar over a character; again asks for a second pass
    function automatic void parse_pass(input st_t s, input logic [7:0] c, output st_t n,
                                       output logic emit, output res_t r,
                                       output logic again);
        logic          sp, dg, lo, up, lt, zero, do_fail, let_ok, row_in;
        logic [2:0]    code;
        logic [7:0]    lp, lc;
        logic [3:0]    dv;
        logic [TB-1:0] acc_dig;
        sp      = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        dg      = (c >= CH_0) && (c <= CH_9);
        lo      = (c >= CH_LA) && (c <= CH_LZ);
        up      = (c >= CH_UA) && (c <= CH_UZ);
        lt      = lo || up;
        zero    = (c == CH_NUL);
        lc      = c | CH_CASE;
        dv      = 4'(c - CH_0);
        acc_dig = (s.acc << 3) + (s.acc << 1) + TB'(dv);
        lp      = lo ? (c - CH_LA) : (c - CH_UA);
        let_ok  = lp < 8'(GRID_SIZE);
        row_in  = (s.acc != '0) && (s.acc <= TB'(GRID_SIZE));
        n       = s;
        emit    = 1'b0;
        r       = '0;
        again   = 1'b0;
        do_fail = 1'b0;
        code    = ERR_UNEXP_END;

        unique case (s.phase)
            PH_ROW_WS, PH_T_WS: begin
                if (zero) begin
                    do_fail = 1'b1;
                    code    = ERR_UNEXP_END;
                end else if (sp) begin
                end else if (dg) begin
                    n.acc   = TB'(dv);
                    n.phase = (s.phase == PH_ROW_WS) ? PH_ROW_LAST : PH_TIME;
                end else begin
                    do_fail = 1'b1;
                    code    = ERR_EXP_NUM;
                end
            end
            PH_ROW_LAST, PH_ROW_FIRST: begin
                if (dg) begin
                    n.acc = acc_dig;
                end else if (!row_in) begin
                    do_fail = 1'b1;
                    code    = ERR_ROW_RANGE;
                end else begin
                    n.row   = CW'(s.acc - TB'(1));
                    n.phase = (s.phase == PH_ROW_LAST) ? PH_POST : PH_COL_WS;
                    again   = 1'b1;
                end
            end
            PH_COL_WS: begin
                if (zero) begin
                    do_fail = 1'b1;
                    code    = ERR_UNEXP_END;
                end else if (sp) begin
                end else if (!lt) begin
                    do_fail = 1'b1;
                    code    = ERR_LETTER;
                end else if (!let_ok) begin
                    do_fail = 1'b1;
                    code    = ERR_COL_RANGE;
                end else begin
                    n.col   = CW'(lp);
                    n.phase = PH_POST;
                end
            end
            PH_POST: begin
                if (zero) begin
                    do_fail = 1'b1;
                    code    = ERR_UNEXP_END;
                end else if (sp) begin
                end else if (s.in_start) begin
                    r.kind      = KIND_START;
                    r.col       = 4'(s.col);
                    r.row       = 4'(s.row);
                    r.col_lead  = s.cf;
                    emit        = 1'b1;
                    n.in_start  = 1'b0;
                    n.phase     = PH_SEP;
                    unique case (lc)
                        CH_N:    r.heading = HEAD_N;
                        CH_E:    r.heading = HEAD_E;
                        CH_S:    r.heading = HEAD_S;
                        CH_W:    r.heading = HEAD_W;
                        default: begin
                            r        = '0;
                            emit     = 1'b0;
                            n        = s;
                            do_fail  = 1'b1;
                            code     = ERR_HEADING;
                        end
                    endcase
                end else if (lc == CH_T) begin
                    n.phase = PH_T_WS;
                end else begin
                    do_fail = 1'b1;
                    code    = ERR_EXP_T;
                end
            end
            PH_SEP: begin
                if (zero) begin
                    r.kind     = KIND_DONE;
                    emit       = 1'b1;
                    n.phase    = PH_LEAD;
                    n.in_start = 1'b1;
                    n.acc      = '0;
                end else if (sp) begin
                    n.phase = PH_LEAD;
                end else begin
                    do_fail = 1'b1;
                    code    = ERR_EXP_WS;
                end
            end
            PH_TIME: begin
                if (dg) begin
                    n.acc = acc_dig;
                end else begin
                    r.kind      = KIND_WAYPOINT;
                    r.col       = 4'(s.col);
                    r.row       = 4'(s.row);
                    r.col_lead  = s.cf;
                    r.time_res  = 16'(s.acc);
                    emit        = 1'b1;
                    n.phase     = PH_SEP;
                    again       = 1'b1;
                end
            end
            PH_DISCARD: begin
                if (zero) begin
                    n.phase    = PH_LEAD;
                    n.in_start = 1'b1;
                    n.acc      = '0;
                end
            end
            default: begin
                // start of a cell, or of a text
                if (zero) begin
                    if (s.in_start) begin
                        do_fail = 1'b1;
                        code    = ERR_UNEXP_END;
                    end else begin
                        r.kind     = KIND_DONE;
                        emit       = 1'b1;
                        n.phase    = PH_LEAD;
                        n.in_start = 1'b1;
                        n.acc      = '0;
                    end
                end else if (sp) begin
                    n.phase = PH_LEAD;
                end else if (lt) begin
                    n.cf = 1'b1;
                    if (let_ok) begin
                        n.col   = CW'(lp);
                        n.phase = PH_ROW_WS;
                    end else begin
                        do_fail = 1'b1;
                        code    = ERR_COL_RANGE;
                    end
                end else if (dg) begin
                    n.cf    = 1'b0;
                    n.acc   = TB'(dv);
                    n.phase = PH_ROW_FIRST;
                end else begin
                    n.cf    = 1'b0;
                    do_fail = 1'b1;
                    code    = ERR_EXP_NUM;
                end
            end
        endcase

        // error record; the zero byte starts a new text, anything else discards
        if (do_fail) begin
            r            = '0;
            r.kind       = KIND_ERROR;
            r.error_code = code;
            emit         = 1'b1;
            if (zero) begin
                n.phase    = PH_LEAD;
                n.in_start = 1'b1;
                n.acc      = '0;
            end else begin
                n.phase = PH_DISCARD;
            end
        end
    endfunction

    st_t  st1, st2;
    logic e1, e2, a1, a2;
    res_t r1, r2;

    // Two chained passes: a number ends at a non-digit that the next phase then reads
    always_comb begin
        parse_pass(state_reg, ch, st1, e1, r1, a1);
        parse_pass(st1, ch, st2, e2, r2, a2);
        if (!a1) begin
            st2 = st1;
            e2  = 1'b0;
            r2  = '0;
        end
        state_next = step_en ? st2 : state_reg;
    end

    // Pack the records for the result buffer and flag the last one
    always_comb begin
        push    = '0;
        push.r0 = e1 ? r1 : r2;
        push.r1 = r2;
        if (step_en) begin
            push.n = {1'b0, e1} + {1'b0, e2};
        end
        if (e1 && e2) begin
            push.r1.last = 1'b1;
        end else begin
            push.r0.last = 1'b1;
        end
    end

    // Parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase    <= PH_LEAD;
            state_reg.acc      <= '0;
            state_reg.col      <= '0;
            state_reg.row      <= '0;
            state_reg.cf       <= 1'b0;
            state_reg.in_start <= 1'b1;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/gitp_rbuf.sv]
// Result buffer: small queue taking up to two records per cycle, one out.
// Depends on gitp_pkg for res_t, push_t and RB_DEPTH.
module gitp_rbuf
    import gitp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  room,
    output logic  m_valid,
    input  logic  m_ready,
    output res_t  m_res
);

    localparam int AW = $clog2(RB_DEPTH);

    res_t            mem_reg [RB_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            pop;

    // Flags and pointers
    assign m_valid     = (count_reg != '0);
    assign m_res       = mem_reg[rd_ptr_reg];
    assign pop         = m_valid && m_ready;
    assign room        = count_reg <= (AW+1)'(RB_DEPTH - 2);
    assign wr_ptr_next = wr_ptr_reg + AW'(push.n);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + (AW+1)'(push.n) - (AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_reg + AW'(1)] <= push.r1;
        end
    end

endmodule

[rtl/grid_itinerary_text_parser_unit.sv]
// Grid itinerary text parser: one ASCII character per request in, records out.
// A character waits in the input register until the buffer has room for two records;
// Throughput: one character per cycle while there is room; a character giving two
// records (a waypoint closed by done or an error) is absorbed by a four-entry buffer.
// Reset (aresetn, synchronous, active low): parser back to start of text, buffer empty.
// Depends on gitp_pkg, gitp_core and gitp_rbuf.
module grid_itinerary_text_parser_unit
    import gitp_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int GRID_SIZE = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_col,
    output logic [3:0]  m_row,
    output logic        m_col_lead,
    output logic [1:0]  m_heading,
    output logic [15:0] m_time_res,
    output logic [2:0]  m_error_code,
    output logic        m_last
);

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       room;
    logic       step_en;
    push_t      push;
    res_t       m_res;

    // Input register; the character is parsed once the buffer has room for two
    assign step_en = in_valid_reg && room;
    assign s_ready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
    end

    gitp_core #(
        .TIME_BITS (TIME_BITS),
        .GRID_SIZE (GRID_SIZE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .ch      (ch_reg),
        .push    (push)
    );

    gitp_rbuf u_rbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    // Result fields
    assign m_kind       = m_res.kind;
    assign m_col        = m_res.col;
    assign m_row        = m_res.row;
    assign m_col_lead   = m_res.col_lead;
    assign m_heading    = m_res.heading;
    assign m_time_res   = m_res.time_res;
    assign m_error_code = m_res.error_code;
    assign m_last       = m_res.last;

    // A held character is not dropped while the buffer is full
    a_hold_char: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !room |=> in_valid_reg && $stable(ch_reg))
        else $error("held character lost while buffer full");

    // Only the final record of a character carries last
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd2 |-> !push.r0.last && push.r1.last)
        else $error("last flag misplaced on a two-record character");

    // Pushed records are visible on the output in the next cycle
    a_push_vis: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |=> m_valid)
        else $error("pushed record not presented");

    // No record is produced without a character being parsed
    a_no_spur: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |-> push.n == 2'd0)
        else $error("record produced without a character");

endmodule
